### sv/quaternion_vector_rotate_core_defines.svh
// Assertion macros used by the checker file of the quaternion rotation core.
// Every macro samples on the rising edge of clk and is switched off while
// rst_n is low, so the module that uses them must have both names in scope.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion rotate core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion rotate core: next-cycle check failed");

`endif

### sv/qvr_pkg.sv
package qvr_pkg;

    // Width of every quaternion, vector and result component.
    localparam int COMP_WIDTH = 16;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;

    typedef struct packed {
        comp_t quat_w;
        comp_t quat_x;
        comp_t quat_y;
        comp_t quat_z;
        comp_t vec_x;
        comp_t vec_y;
        comp_t vec_z;
    } qvr_in_t;

    typedef struct packed {
        comp_t rot_x;
        comp_t rot_y;
        comp_t rot_z;
        logic  clipped;
    } qvr_out_t;

endpackage

### sv/quaternion_vector_rotate_core.sv
// Quaternion vector rotation core. Each transfer on the input channel carries a
// quaternion q in signed Q2.14 and an integer vector v; the core returns
// q * (0, v) * conj(q) at full precision, divided by 2^28 with round half up,
// saturated to signed 16 bits per component, with clipped raised when any
// component was clamped. A quaternion that is not of unit length also scales
// the vector by |q|^2. The datapath is a six-stage pipeline: the first
// Hamilton product's multiplies, its sums, the second product's multiplies
// (each cut into a low and a high half of the first product), partial sums,
// the recombination with the rounding offset, and saturation into the output
// register. A result is offered once it has been loaded into the output
// register, and the core takes one item in every cycle while out_ready is
// high. Each stage holds its own valid bit and loads whenever it is empty or
// its successor moves on, so a stall on the output fills bubbles before it
// ever blocks the input, and nothing is dropped or repeated. There is no
// state between items and no configuration.
module quaternion_vector_rotate_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qvr_pkg::qvr_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output qvr_pkg::qvr_out_t out_data
);

    import qvr_pkg::*;

    localparam int N       = COMP_WIDTH;
    localparam int STAGES  = 6;
    // Products of two components, and the first Hamilton product.
    localparam int M1_W    = 2 * N;
    localparam int P_W     = 2 * N + 2;
    // The first product is split into an unsigned low half and a signed high
    // half so that no multiplier in the second product is wider than N+2 bits.
    localparam int LO_W    = N + 1;
    localparam int HI_W    = P_W - LO_W;
    localparam int M2_W    = 2 * N + 2;
    localparam int SUM_W   = M2_W + 2;
    localparam int RW      = SUM_W + LO_W + 1;
    // The result carries two factors of the quaternion scale, 2^(N-2) each.
    localparam int SHIFT   = 2 * (N - 2);

    localparam logic [RW-1:0] ROUND_OFS = {{(RW-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};
    localparam comp_t COMP_MAX = {1'b0, {(N-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(N-1){1'b0}}};

    // Sign of each term of the second product. Row k gives rotated component
    // k+1; column j is the first-product component that enters the term. The
    // quaternion part used with column j of row k is component j ^ (k+1).
    localparam logic [3:0] NEG_MASK [3] = '{4'b0100, 4'b1000, 4'b0010};

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its successor advances.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] en;

    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        for (int i = 0; i < STAGES; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: the twelve products of q * (0, v).
    // ------------------------------------------------------------------
    logic signed [M1_W-1:0] m1_reg  [12];
    logic signed [M1_W-1:0] m1_next [12];
    comp_t                  qa_reg  [4];

    always_comb
    begin
        // Terms of the negated scalar part.
        m1_next[0]  = M1_W'(in_data.quat_x) * M1_W'(in_data.vec_x);
        m1_next[1]  = M1_W'(in_data.quat_y) * M1_W'(in_data.vec_y);
        m1_next[2]  = M1_W'(in_data.quat_z) * M1_W'(in_data.vec_z);
        // i part.
        m1_next[3]  = M1_W'(in_data.quat_w) * M1_W'(in_data.vec_x);
        m1_next[4]  = M1_W'(in_data.quat_y) * M1_W'(in_data.vec_z);
        m1_next[5]  = M1_W'(in_data.quat_z) * M1_W'(in_data.vec_y);
        // j part.
        m1_next[6]  = M1_W'(in_data.quat_w) * M1_W'(in_data.vec_y);
        m1_next[7]  = M1_W'(in_data.quat_x) * M1_W'(in_data.vec_z);
        m1_next[8]  = M1_W'(in_data.quat_z) * M1_W'(in_data.vec_x);
        // k part.
        m1_next[9]  = M1_W'(in_data.quat_w) * M1_W'(in_data.vec_z);
        m1_next[10] = M1_W'(in_data.quat_x) * M1_W'(in_data.vec_y);
        m1_next[11] = M1_W'(in_data.quat_y) * M1_W'(in_data.vec_x);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m1_reg    <= m1_next;
            qa_reg[0] <= in_data.quat_w;
            qa_reg[1] <= in_data.quat_x;
            qa_reg[2] <= in_data.quat_y;
            qa_reg[3] <= in_data.quat_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the first Hamilton product. Slot 0 holds the negated scalar
    // part, which is what the second product needs with a positive sign.
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] p_reg  [4];
    logic signed [P_W-1:0] p_next [4];
    comp_t                 qb_reg [4];

    always_comb
    begin
        p_next[0] = P_W'(m1_reg[0]) + P_W'(m1_reg[1])  + P_W'(m1_reg[2]);
        p_next[1] = P_W'(m1_reg[3]) + P_W'(m1_reg[4])  - P_W'(m1_reg[5]);
        p_next[2] = P_W'(m1_reg[6]) - P_W'(m1_reg[7])  + P_W'(m1_reg[8]);
        p_next[3] = P_W'(m1_reg[9]) + P_W'(m1_reg[10]) - P_W'(m1_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg  <= p_next;
            qb_reg <= qa_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the second product's multiplies, split by halves of p.
    // ------------------------------------------------------------------
    logic signed [M2_W-1:0] hi_reg  [3][4];
    logic signed [M2_W-1:0] hi_next [3][4];
    logic signed [M2_W-1:0] lo_reg  [3][4];
    logic signed [M2_W-1:0] lo_next [3][4];

    always_comb
    begin
        logic signed [HI_W-1:0] p_hi;
        logic signed [LO_W:0]   p_lo;
        logic [1:0]             qi;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                qi            = 2'(j) ^ 2'(k + 1);
                p_hi          = $signed(p_reg[j][P_W-1:LO_W]);
                p_lo          = $signed({1'b0, p_reg[j][LO_W-1:0]});
                hi_next[k][j] = M2_W'(p_hi) * M2_W'(qb_reg[qi]);
                lo_next[k][j] = M2_W'(p_lo) * M2_W'(qb_reg[qi]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: signed sums of the high and of the low partial products.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] hsum_reg  [3];
    logic signed [SUM_W-1:0] hsum_next [3];
    logic signed [SUM_W-1:0] lsum_reg  [3];
    logic signed [SUM_W-1:0] lsum_next [3];

    always_comb
    begin
        logic signed [SUM_W-1:0] h_term;
        logic signed [SUM_W-1:0] l_term;
        for (int k = 0; k < 3; k++)
        begin
            hsum_next[k] = '0;
            lsum_next[k] = '0;
            for (int j = 0; j < 4; j++)
            begin
                h_term = SUM_W'(hi_reg[k][j]);
                l_term = SUM_W'(lo_reg[k][j]);
                if (NEG_MASK[k][j])
                begin
                    hsum_next[k] = hsum_next[k] - h_term;
                    lsum_next[k] = lsum_next[k] - l_term;
                end
                else
                begin
                    hsum_next[k] = hsum_next[k] + h_term;
                    lsum_next[k] = lsum_next[k] + l_term;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            hsum_reg <= hsum_next;
            lsum_reg <= lsum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine the halves and add the rounding offset.
    // ------------------------------------------------------------------
    logic signed [RW-1:0] rnd_reg  [3];
    logic signed [RW-1:0] rnd_next [3];

    always_comb
    begin
        logic signed [RW-1:0] h_ext;
        logic signed [RW-1:0] l_ext;
        for (int k = 0; k < 3; k++)
        begin
            h_ext       = RW'(hsum_reg[k]);
            l_ext       = RW'(lsum_reg[k]);
            rnd_next[k] = (h_ext <<< LO_W) + l_ext + $signed(ROUND_OFS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            rnd_reg <= rnd_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: drop the fraction, saturate and flag any clamp.
    // ------------------------------------------------------------------
    qvr_out_t out_reg;
    qvr_out_t out_next;

    always_comb
    begin
        comp_t                   comp [3];
        logic [RW-SHIFT-N:0]     top_bits;
        logic                    fits;
        logic                    clip;
        clip = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            top_bits = rnd_reg[k][RW-1:SHIFT+N-1];
            fits     = (&top_bits) || !(|top_bits);
            if (fits)
            begin
                comp[k] = rnd_reg[k][SHIFT+N-1:SHIFT];
            end
            else
            begin
                comp[k] = rnd_reg[k][RW-1] ? COMP_MIN : COMP_MAX;
                clip    = 1'b1;
            end
        end
        out_next.rot_x   = comp[0];
        out_next.rot_y   = comp[1];
        out_next.rot_z   = comp[2];
        out_next.clipped = clip;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

### sv/qvr_checker.sv
`include "quaternion_vector_rotate_core_defines.svh"

module qvr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input qvr_pkg::qvr_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input qvr_pkg::qvr_out_t out_data
);

    import qvr_pkg::*;

    localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    logic x_at_limit;
    logic y_at_limit;
    logic z_at_limit;

    assign x_at_limit = (out_data.rot_x == COMP_MAX) || (out_data.rot_x == COMP_MIN);
    assign y_at_limit = (out_data.rot_y == COMP_MAX) || (out_data.rot_y == COMP_MIN);
    assign z_at_limit = (out_data.rot_z == COMP_MAX) || (out_data.rot_z == COMP_MIN);

    // A result that is waiting keeps being offered.
    `QVR_ASSERT_NEXT(a_out_valid_held, out_valid && !out_ready, out_valid)

    // A waiting result does not change under the consumer.
    `QVR_ASSERT_NEXT(a_out_data_held, out_valid && !out_ready, $stable(out_data))

    // When the consumer takes results, the pipeline never holds off the producer.
    `QVR_ASSERT_SAME(a_no_backpressure, out_ready, in_ready)

    // A clamp always leaves at least one component at a limit of its range.
    `QVR_ASSERT_SAME(a_clip_at_limit, out_valid && out_data.clipped,
                     x_at_limit || y_at_limit || z_at_limit)

    // An empty output register never holds off the producer.
    `QVR_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (.*);
